// ----- hw/rtl/ffa_pkg.sv -----
// ffa_pkg: shared codes and fixed field widths of the first-fit allocator
// no dependencies

package ffa_pkg;

  // fixed beat field widths
  localparam int unsigned CmdW    = 1;
  localparam int unsigned ReqW    = 17;
  localparam int unsigned OffW    = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FreeW   = 17;

  // command codes
  localparam logic [CmdW-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CmdW-1:0] CMD_FREE  = 1'b1;

  // status codes
  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_ZERO     = 2'd1;
  localparam logic [StatusW-1:0] ST_OOM      = 2'd2;
  localparam logic [StatusW-1:0] ST_BAD_FREE = 2'd3;

  // header flag bits
  localparam logic [1:0] FLG_NONE  = 2'b00;
  localparam logic [1:0] FLG_VALID = 2'b01;
  localparam logic [1:0] FLG_VFREE = 2'b11;

  // request rounding to 4 bytes
  localparam logic [ReqW:0] RND_ADD  = (ReqW+1)'(3);
  localparam logic [ReqW:0] RND_MASK = ~((ReqW+1)'(3));

endpackage

// ----- hw/rtl/ffa_hdr_mem.sv -----
// ffa_hdr_mem: header store, one write port and one registered read port
// no package dependency

module ffa_hdr_mem #(
  parameter int unsigned Depth = 16384,
  parameter int unsigned Width = 34
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/first_fit_boundary_tag_allocator.sv -----
// first_fit_boundary_tag_allocator: top level, sequencer around the header store
// depends on ffa_pkg and ffa_hdr_mem

// First-fit heap allocator with boundary tags. One beat is handled at a time.
// After reset the header store is cleared, one entry per cycle, all
// HEAP_BYTES/4 entries (16384 at the default size), before the first beat is
// taken. An allocate accepts the beat, walks the block headers first-fit with
// one store read per header visited, writes the split headers and then loads
// the result. A free makes up to four store reads and up to four writes. A
// zero size allocate or a null free goes straight to the result. The result
// then sits in an output register until taken, and the next beat is accepted
// once the result is loaded there. HEADER_BYTES must be a multiple of 4.

module first_fit_boundary_tag_allocator #(
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ffa_pkg::CmdW-1:0]      cmd_i,
  input  logic [ffa_pkg::ReqW-1:0]      req_bytes_i,
  input  logic [ffa_pkg::OffW-1:0]      payload_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ffa_pkg::StatusW-1:0]   status_o,
  output logic [ffa_pkg::OffW-1:0]      granted_offset_o,
  output logic [ffa_pkg::FreeW-1:0]     free_bytes_o
);

  import ffa_pkg::*;

  localparam int unsigned OW    = $clog2(HEAP_BYTES);
  localparam int unsigned AW    = OW - 2;
  localparam int unsigned Depth = HEAP_BYTES / 4;
  localparam int unsigned CW    = ((OW > ReqW + 1) ? OW : ReqW + 1) + 1;
  localparam logic [CW-1:0] HDR  = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] HEAP = CW'(HEAP_BYTES);
  localparam logic [CW-1:0] INIT = CW'(HEAP_BYTES - HEADER_BYTES);

  typedef struct packed {
    logic [OW-1:0] size;
    logic [OW-1:0] prev;
    logic [1:0]    flags;
  } hdr_t;

  localparam int unsigned HW = $bits(hdr_t);

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_A_CHK = 14'b00000000000100,
    S_A_W1  = 14'b00000000001000,
    S_A_W2  = 14'b00000000010000,
    S_F_CHK = 14'b00000000100000,
    S_F_RP  = 14'b00000001000000,
    S_F_RN  = 14'b00000010000000,
    S_F_W1  = 14'b00000100000000,
    S_F_W2  = 14'b00001000000000,
    S_F_W3  = 14'b00010000000000,
    S_F_RA  = 14'b00100000000000,
    S_F_WA  = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [AW:0]        clr_q, clr_d;
  logic [CW-1:0]      fcnt_q, fcnt_d;
  logic [OW-1:0]      cur_q, cur_d;
  logic [OW-1:0]      nw_q, nw_d;
  logic [CW-1:0]      nxt_q, nxt_d;
  logic [CW-1:0]      aft_q, aft_d;
  logic [CW-1:0]      rnd_q, rnd_d;
  logic [CW-1:0]      need_q, need_d;
  hdr_t               eo_q, eo_d;
  hdr_t               ep_q, ep_d;
  hdr_t               en_q, en_d;
  logic               pf_q, pf_d, nf_q, nf_d;
  logic [StatusW-1:0] rst_st_q, rst_st_d;
  logic [OffW-1:0]    rgnt_q, rgnt_d;

  logic               out_valid_q;
  logic [StatusW-1:0] status_q;
  logic [OffW-1:0]    grant_q;
  logic [FreeW-1:0]   free_q;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  hdr_t               mem_wdata, rd;
  logic [HW-1:0]      mem_rdata;

  logic               in_acc, out_load;
  logic [ReqW:0]      rounded;
  logic [CW-1:0]      ptr_w, walk_nxt, sz;

  assign rd = hdr_t'(mem_rdata);

  ffa_hdr_mem #(
    .Depth(Depth),
    .Width(HW)
  ) u_hdr_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign rounded    = ({1'b0, req_bytes_i} + RND_ADD) & RND_MASK;
  assign ptr_w      = CW'(payload_offset_i);
  assign walk_nxt   = CW'(cur_q) + HDR + CW'(rd.size);
  assign sz         = CW'(eo_q.size);

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    fcnt_d    = fcnt_q;
    cur_d     = cur_q;
    nw_d      = nw_q;
    nxt_d     = nxt_q;
    aft_d     = aft_q;
    rnd_d     = rnd_q;
    need_d    = need_q;
    eo_d      = eo_q;
    ep_d      = ep_q;
    en_d      = en_q;
    pf_d      = pf_q;
    nf_d      = nf_q;
    rst_st_d  = rst_st_q;
    rgnt_d    = rgnt_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q[AW-1:0];
        if (clr_q == '0) begin
          mem_wdata = '{size: OW'(INIT), prev: '0, flags: FLG_VFREE};
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == (AW+1)'(Depth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          rgnt_d = '0;
          if (cmd_i == CMD_ALLOC) begin
            if (req_bytes_i == '0) begin
              rst_st_d = ST_ZERO;
              state_d  = S_DONE;
            end else begin
              rnd_d     = CW'(rounded);
              need_d    = CW'(rounded) + HDR;
              cur_d     = '0;
              mem_re    = 1'b1;
              mem_raddr = '0;
              state_d   = S_A_CHK;
            end
          end else begin
            if (payload_offset_i == '0) begin
              rst_st_d = ST_OK;
              state_d  = S_DONE;
            end else if (ptr_w < HDR || ptr_w >= HEAP - HDR
                         || payload_offset_i[1:0] != 2'b00) begin
              rst_st_d = ST_BAD_FREE;
              state_d  = S_DONE;
            end else begin
              cur_d     = OW'(ptr_w - HDR);
              mem_re    = 1'b1;
              mem_raddr = AW'((ptr_w - HDR) >> 2);
              state_d   = S_F_CHK;
            end
          end
        end
      end
      // first-fit walk, one header per cycle
      S_A_CHK: begin
        if (rd.flags == FLG_VFREE && CW'(rd.size) >= need_q) begin
          nw_d      = OW'(CW'(cur_q) + need_q);
          mem_we    = 1'b1;
          mem_waddr = AW'((CW'(cur_q) + need_q) >> 2);
          mem_wdata = '{size: OW'(CW'(rd.size) - need_q), prev: cur_q, flags: FLG_VFREE};
          eo_d      = rd;
          nxt_d     = walk_nxt;
          fcnt_d    = fcnt_q - need_q;
          rst_st_d  = ST_OK;
          rgnt_d    = OffW'(CW'(cur_q) + HDR);
          if (walk_nxt < HEAP) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(walk_nxt >> 2);
          end
          state_d = S_A_W1;
        end else if (walk_nxt < HEAP) begin
          cur_d     = OW'(walk_nxt);
          mem_re    = 1'b1;
          mem_raddr = AW'(walk_nxt >> 2);
        end else begin
          rst_st_d = ST_OOM;
          state_d  = S_DONE;
        end
      end
      S_A_W1: begin
        mem_we    = 1'b1;
        mem_waddr = cur_q[OW-1:2];
        mem_wdata = '{size: OW'(rnd_q), prev: eo_q.prev, flags: FLG_VALID};
        state_d   = (nxt_q < HEAP) ? S_A_W2 : S_DONE;
      end
      S_A_W2: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(nxt_q >> 2);
        mem_wdata = '{size: rd.size, prev: nw_q, flags: rd.flags};
        state_d   = S_DONE;
      end
      // free: check the block, then fetch both neighbors
      S_F_CHK: begin
        if (rd.flags != FLG_VALID) begin
          rst_st_d = ST_BAD_FREE;
          state_d  = S_DONE;
        end else begin
          eo_d      = rd;
          nxt_d     = walk_nxt;
          mem_re    = 1'b1;
          mem_raddr = rd.prev[OW-1:2];
          state_d   = S_F_RP;
        end
      end
      S_F_RP: begin
        pf_d = (cur_q != '0) && (rd.flags == FLG_VFREE);
        ep_d = rd;
        if (nxt_q < HEAP) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(nxt_q >> 2);
        end
        state_d = S_F_RN;
      end
      S_F_RN: begin
        nf_d     = (nxt_q < HEAP) && (rd.flags == FLG_VFREE);
        en_d     = rd;
        aft_d    = nxt_q + HDR + CW'(rd.size);
        fcnt_d   = fcnt_q + sz + (pf_q ? HDR : '0)
                   + (((nxt_q < HEAP) && (rd.flags == FLG_VFREE)) ? HDR : '0);
        rst_st_d = ST_OK;
        state_d  = S_F_W1;
      end
      // merge writes
      S_F_W1: begin
        mem_we = 1'b1;
        if (pf_q) begin
          mem_waddr = eo_q.prev[OW-1:2];
          mem_wdata = '{size: OW'(CW'(ep_q.size) + sz + HDR
                                  + (nf_q ? CW'(en_q.size) + HDR : '0)),
                        prev: ep_q.prev, flags: ep_q.flags};
        end else begin
          mem_waddr = cur_q[OW-1:2];
          mem_wdata = '{size: OW'(sz + (nf_q ? CW'(en_q.size) + HDR : '0)),
                        prev: eo_q.prev, flags: FLG_VFREE};
        end
        state_d = (pf_q || nf_q) ? S_F_W2 : S_DONE;
      end
      S_F_W2: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        mem_waddr = pf_q ? cur_q[OW-1:2] : AW'(nxt_q >> 2);
        priority if (pf_q && (nf_q || nxt_q < HEAP)) begin
          state_d = S_F_W3;
        end else if (nf_q && aft_q < HEAP) begin
          state_d = S_F_RA;
        end else begin
          state_d = S_DONE;
        end
      end
      S_F_W3: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(nxt_q >> 2);
        if (nf_q) begin
          mem_wdata = '0;
        end else begin
          mem_wdata = '{size: en_q.size, prev: eo_q.prev, flags: en_q.flags};
        end
        state_d   = (nf_q && aft_q < HEAP) ? S_F_RA : S_DONE;
      end
      S_F_RA: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(aft_q >> 2);
        state_d   = S_F_WA;
      end
      S_F_WA: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(aft_q >> 2);
        mem_wdata = '{size: rd.size, prev: pf_q ? eo_q.prev : cur_q, flags: rd.flags};
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      fcnt_q      <= INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      fcnt_q  <= fcnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working payload registers
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    nw_q     <= nw_d;
    nxt_q    <= nxt_d;
    aft_q    <= aft_d;
    rnd_q    <= rnd_d;
    need_q   <= need_d;
    eo_q     <= eo_d;
    ep_q     <= ep_d;
    en_q     <= en_d;
    pf_q     <= pf_d;
    nf_q     <= nf_d;
    rst_st_q <= rst_st_d;
    rgnt_q   <= rgnt_d;
    if (out_load) begin
      status_q <= rst_st_q;
      grant_q  <= rgnt_q;
      free_q   <= FreeW'(fcnt_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign granted_offset_o = grant_q;
  assign free_bytes_o     = free_q;

`ifndef ASSERT_OFF
  a_fcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= INIT)
    else $error("free byte count above heap capacity");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !mem_we)
    else $error("header write outside a command");

  a_zero_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd_i == CMD_ALLOC && req_bytes_i == '0)
      |=> (state_q == S_DONE && rst_st_q == ST_ZERO))
    else $error("zero size allocate not reported at once");

  a_load_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result loaded outside done state");
`endif

endmodule

// ----- tb/testbench.sv -----
// testbench for first_fit_boundary_tag_allocator: directed and random alloc/free beats
// checked against a behavioral heap model kept inside the bench; depends on ffa_pkg
`timescale 1ns / 100ps

module testbench;
  import ffa_pkg::*;

  localparam int unsigned HEAP   = 65536;
  localparam int unsigned HDR    = 16;
  localparam int unsigned LIMIT  = 20000000;
  localparam int unsigned MAX_LIVE = 48;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [OffW-1:0]    granted;
    logic [FreeW-1:0]   free_bytes;
  } heap_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [CmdW-1:0]    cmd_i;
  logic [ReqW-1:0]    req_bytes_i;
  logic [OffW-1:0]    payload_offset_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [StatusW-1:0] status_o;
  logic [OffW-1:0]    granted_offset_o;
  logic [FreeW-1:0]   free_bytes_o;

  first_fit_boundary_tag_allocator #(
    .HEAP_BYTES  (HEAP),
    .HEADER_BYTES(HDR)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .req_bytes_i     (req_bytes_i),
    .payload_offset_i(payload_offset_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .granted_offset_o(granted_offset_o),
    .free_bytes_o    (free_bytes_o)
  );

  // heap model state: one header slot per byte offset
  int unsigned blk_size [HEAP];
  int unsigned blk_prev [HEAP];
  logic [1:0]  blk_flags[HEAP];
  int unsigned heap_free;
  int unsigned last_grant;

  heap_result_t pending_results[$];
  int unsigned  live_offsets[$];
  int unsigned  freed_offsets[$];
  int unsigned  errors;
  int unsigned  cycles;
  bit           idle_on;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // cycle limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  function automatic void heap_reset();
    for (int i = 0; i < HEAP; i++) begin
      blk_size[i]  = 0;
      blk_prev[i]  = 0;
      blk_flags[i] = FLG_NONE;
    end
    blk_size[0]  = HEAP - HDR;
    blk_flags[0] = FLG_VFREE;
    heap_free    = HEAP - HDR;
  endfunction

  function automatic int unsigned next_block(int unsigned off);
    return off + HDR + blk_size[off];
  endfunction

  function automatic bit is_free(int unsigned off);
    return blk_flags[off][1];
  endfunction

  // first-fit allocate with split
  function automatic logic [StatusW-1:0] heap_alloc(int unsigned req);
    int unsigned rounded, need, off, nw, old_next;
    if (req == 0) return ST_ZERO;
    rounded = (req + 3) & ~32'd3;
    need    = rounded + HDR;
    off     = 0;
    while (off < HEAP) begin
      if (is_free(off) && blk_size[off] >= need) begin
        nw       = off + need;
        old_next = next_block(off);
        blk_prev[nw]  = off;
        blk_size[nw]  = blk_size[off] - need;
        blk_flags[nw] = FLG_VFREE;
        if (old_next < HEAP) blk_prev[old_next] = nw;
        blk_size[off]  = rounded;
        blk_flags[off] = FLG_VALID;
        heap_free -= need;
        last_grant = off + HDR;
        return ST_OK;
      end
      off = next_block(off);
    end
    return ST_OOM;
  endfunction

  // release with coalescing of free neighbors
  function automatic logic [StatusW-1:0] heap_release(int unsigned ptr);
    int unsigned off, nxt, prv, after;
    bit pf, nf;
    if (ptr == 0) return ST_OK;
    if (ptr < HDR || ptr >= HEAP - HDR) return ST_BAD_FREE;
    off = ptr - HDR;
    if (!blk_flags[off][0] || is_free(off)) return ST_BAD_FREE;
    nxt = next_block(off);
    prv = blk_prev[off];
    pf  = (off != 0) && is_free(prv);
    nf  = (nxt < HEAP) && is_free(nxt);
    if (pf && nf) begin
      after = next_block(nxt);
      heap_free += blk_size[off] + 2 * HDR;
      blk_size[prv] += blk_size[off] + blk_size[nxt] + 2 * HDR;
      if (after < HEAP) blk_prev[after] = prv;
      blk_flags[off] = FLG_NONE;
      blk_flags[nxt] = FLG_NONE;
    end else if (pf) begin
      heap_free += blk_size[off] + HDR;
      blk_size[prv] += blk_size[off] + HDR;
      if (nxt < HEAP) blk_prev[nxt] = prv;
      blk_flags[off] = FLG_NONE;
    end else if (nf) begin
      after = next_block(nxt);
      heap_free += blk_size[off] + HDR;
      blk_size[off] += blk_size[nxt] + HDR;
      blk_flags[off] = FLG_VFREE;
      if (after < HEAP) blk_prev[after] = off;
      blk_flags[nxt] = FLG_NONE;
    end else begin
      heap_free += blk_size[off];
      blk_flags[off] = FLG_VFREE;
    end
    return ST_OK;
  endfunction

  function automatic heap_result_t predict_heap_op(logic [CmdW-1:0] cmd,
                                                   logic [ReqW-1:0] req,
                                                   logic [OffW-1:0] ptr);
    heap_result_t r;
    last_grant = 0;
    if (cmd == CMD_ALLOC) r.status = heap_alloc(req);
    else                  r.status = heap_release(ptr);
    r.granted    = last_grant[OffW-1:0];
    r.free_bytes = heap_free[FreeW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // result side: random stall and field checks
  initial begin
    heap_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result beat", status_o, 0);
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", status_o, want.status);
          if (granted_offset_o !== want.granted)
            report_mismatch("granted_offset", granted_offset_o, want.granted);
          if (free_bytes_o !== want.free_bytes)
            report_mismatch("free_bytes", free_bytes_o, want.free_bytes);
        end
      end
      out_stall_i <= idle_on && ($urandom_range(99) < 29);
    end
  end

  // send one beat, predict it on acceptance; valid stays high on return
  task automatic send_beat(logic [CmdW-1:0] cmd, logic [ReqW-1:0] req,
                           logic [OffW-1:0] ptr);
    heap_result_t r;
    while (idle_on && ($urandom_range(99) < 29)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    cmd_i            <= cmd;
    req_bytes_i      <= req;
    payload_offset_i <= ptr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = predict_heap_op(cmd, req, ptr);
    pending_results.push_back(r);
    if (cmd == CMD_ALLOC && r.status == ST_OK) live_offsets.push_back(last_grant);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic free_live(int unsigned idx);
    int unsigned p;
    p = live_offsets[idx];
    live_offsets.delete(idx);
    send_beat(CMD_FREE, '0, p[OffW-1:0]);
    freed_offsets.push_back(p);
    if (freed_offsets.size() > 16) void'(freed_offsets.pop_front());
  endtask

  // field extremes and every status code
  task automatic test_edges();
    send_beat(CMD_ALLOC, '0, '1);
    send_beat(CMD_ALLOC, 17'd65536, '0);
    send_beat(CMD_ALLOC, 17'd65505, '0);
    send_beat(CMD_FREE, '1, '0);
    send_beat(CMD_FREE, '0, 16'd5);
    send_beat(CMD_FREE, '0, 16'd65520);
    send_beat(CMD_FREE, '0, 16'hFFFF);
    send_beat(CMD_ALLOC, 17'd1, '0);
    send_beat(CMD_ALLOC, 17'd3, '0);
    send_beat(CMD_ALLOC, 17'd4, '0);
    send_beat(CMD_FREE, '0, 16'd22);
    while (live_offsets.size() != 0) free_live(0);
    send_beat(CMD_FREE, '0, freed_offsets[$]);
  endtask

  // each coalescing shape, then an exact fit
  task automatic test_merges();
    for (int i = 0; i < 3; i++) send_beat(CMD_ALLOC, 17'd40, '0);
    free_live(1);
    free_live(0);
    free_live(0);
    for (int i = 0; i < 3; i++) send_beat(CMD_ALLOC, 17'd100, '0);
    free_live(0);
    free_live(0);
    free_live(0);
    send_beat(CMD_ALLOC, 17'd65504, '0);
    send_beat(CMD_ALLOC, 17'd1, '0);
    free_live(0);
  endtask

  // random mix, mostly frees of live blocks and small allocations
  task automatic test_random(int unsigned n);
    int unsigned pick, req;
    for (int unsigned i = 0; i < n; i++) begin
      idle_on = !(i >= n / 3 && i < n / 2);
      if (i == (2 * n) / 3) wait_drained();
      pick = $urandom_range(99);
      if (live_offsets.size() != 0 &&
          (pick < 40 || live_offsets.size() >= MAX_LIVE)) begin
        free_live($urandom_range(live_offsets.size() - 1));
      end else if (pick < 47) begin
        if (freed_offsets.size() != 0 && pick < 44)
          send_beat(CMD_FREE, '0, freed_offsets[$urandom_range(freed_offsets.size() - 1)]);
        else
          send_beat(CMD_FREE, ReqW'($urandom), OffW'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 2)       req = 0;
        else if (pick < 85) req = $urandom_range(256, 1);
        else if (pick < 96) req = $urandom_range(4096, 257);
        else                req = $urandom_range(65536, 4097);
        send_beat(CMD_ALLOC, req[ReqW-1:0], OffW'($urandom));
      end
    end
    idle_on = 1'b1;
  endtask

  // stimulus sequence and final verdict
  initial begin
    errors           = 0;
    idle_on          = 1'b1;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    out_stall_i      = 1'b0;
    cmd_i            = CMD_ALLOC;
    req_bytes_i      = '0;
    payload_offset_i = '0;
    heap_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_edges();
    test_merges();
    test_random(2000);
    wait_drained();
    repeat (64) @(posedge clk_i);
    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
